// ===== rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the pattern occurrence counter: item modes,
// configuration register indexes, field widths and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

    // field widths
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned MODE_W       = 2;
    localparam int unsigned LEN_W        = 6;
    localparam int unsigned TOTAL_W      = 32;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned CFG_INDEX_W  = 3;

    // pattern byte registers: four words of eight bytes
    localparam int unsigned NUM_BYTE_REGS = 4;
    localparam int unsigned BYTES_PER_REG = 8;
    localparam int unsigned REG_BYTES     = NUM_BYTE_REGS * BYTES_PER_REG;

    // cell index width, covers up to 256 cells
    localparam int unsigned IDX_W = 8;
    // effective length width, holds up to 256
    localparam int unsigned EFF_W = 9;

    // item modes
    typedef enum logic [MODE_W-1:0] {
        MODE_START      = 2'd0,
        MODE_TEXT       = 2'd1,
        MODE_LINE_BREAK = 2'd2
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LENGTH   = 3'd0,
        REG_BYTES_0  = 3'd1,
        REG_BYTES_8  = 3'd2,
        REG_BYTES_16 = 3'd3,
        REG_BYTES_24 = 3'd4
    } cfg_reg_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic              load;
        logic              clear;
        logic              step;
        logic [BYTE_W-1:0] text_byte;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/kmp_if.sv =====
// ----------------------------------------------------------------------------
// kmp_if
// Valid/ready channels of the occurrence counter: the item channel carrying
// mode and text byte, and the result channel carrying match flag and total.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmp_item_if
    import kmp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output mode, output text_byte, input ready);
    modport sink   (input valid, input mode, input text_byte, output ready);
endinterface

interface kmp_result_if
    import kmp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               match_found;
    logic [TOTAL_W-1:0] match_total;

    modport source (output valid, output match_found, output match_total, input ready);
    modport sink   (input valid, input match_found, input match_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/kmp_cell.sv =====
// ----------------------------------------------------------------------------
// kmp_cell
// One pattern position. Holds its pattern byte, whether it is the final
// position, and whether the text so far ends in the pattern prefix through
// this position; the flag is handed on to the next cell every step.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_cell
    import kmp_pkg::*;
#(
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [BYTE_W-1:0] pattern_byte,
    input  wire logic [IDX_W-1:0]  last_index,
    input  wire logic              prev_match,
    output logic                   match,
    output logic                   hit
);

    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              match_reg;

    // pattern byte, latched at start
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            byte_reg <= pattern_byte;
        end
    end

    // final position flag and prefix match flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            last_reg  <= (last_index == IDX_W'(CELL_INDEX));
            match_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            match_reg <= prev_match && (byte_reg == ctrl.text_byte);
        end
    end

    assign match = match_reg;
    assign hit   = match_reg && last_reg;

endmodule

`default_nettype wire

// ===== rtl/kmp_occurrence_counter.sv =====
// ----------------------------------------------------------------------------
// kmp_occurrence_counter
// Counts overlapping occurrences of a byte pattern in a text stream, with a
// row of one cell per pattern position.
// ----------------------------------------------------------------------------
// Usage:
//   items   : valid/ready channel; mode start (latch pattern, clear count),
//             text (one byte), or line break (drop partial matches).
//   results : one transaction per item: match_found for a text byte that
//             completes an occurrence, and the saturating running total.
//   wr_*    : register writes (length, four pattern byte words), acting at the next
//             start item; the user makes them only with no item in flight, unenforced.
// Timing:
//   an item is taken into the cell row and the first stage at its accepting
//   edge; the result is registered when the first stage advances, which a
//   stalled result can hold off, and result valid rises with that register.
//   One item per cycle unless the result stage stalls: every cell updates its
//   prefix flag from its neighbor in the same cycle, so no failure-link walk.
// Reset clears the registers to length 1 and zero bytes, the count, the
// pipeline and the ready flag; text before the first start never matches.
// A stalled result holds the result stage, which in turn holds items off.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_occurrence_counter
    import kmp_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    kmp_item_if.sink                    items,
    kmp_result_if.source                results,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data
);

    // configuration registers
    logic [LEN_W-1:0]                          length_reg;
    logic [NUM_BYTE_REGS-1:0][CFG_DATA_W-1:0] bytes_reg;

    // search state and pipeline
    logic               table_ready_reg;
    logic               s1_valid_reg;
    mode_t              s1_mode_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               found_next;

    logic               item_accept;
    logic               s1_advance;
    mode_t              item_mode;
    cell_ctrl_t         ctrl;
    logic [EFF_W-1:0]   eff_length;
    logic [IDX_W-1:0]   last_index;
    logic [MAX_PATTERN:0]   chain;
    logic [MAX_PATTERN-1:0] hit_vec;
    logic               hit_any;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_W'(1);
            bytes_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_LENGTH:   length_reg   <= wr_data[LEN_W-1:0];
                REG_BYTES_0:  bytes_reg[0] <= wr_data;
                REG_BYTES_8:  bytes_reg[1] <= wr_data;
                REG_BYTES_16: bytes_reg[2] <= wr_data;
                REG_BYTES_24: bytes_reg[3] <= wr_data;
                default:      ;
            endcase
        end
    end

    // length clamped to 1..MAX_PATTERN, then index of the final cell
    always_comb
    begin
        eff_length = (length_reg == '0) ? EFF_W'(1) : EFF_W'(length_reg);
        if (eff_length > EFF_W'(MAX_PATTERN))
        begin
            eff_length = EFF_W'(MAX_PATTERN);
        end
        last_index = IDX_W'(eff_length - EFF_W'(1));
    end

    // handshake and cell control
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready  = !s1_valid_reg || s1_advance;
    assign item_accept  = items.valid && items.ready;
    assign item_mode    = mode_t'(items.mode);

    always_comb
    begin
        ctrl.load      = 1'b0;
        ctrl.clear     = 1'b0;
        ctrl.step      = 1'b0;
        ctrl.text_byte = items.text_byte;
        if (item_accept)
        begin
            case (item_mode)
                MODE_START:      ctrl.load  = 1'b1;
                MODE_TEXT:       ctrl.step  = table_ready_reg;
                MODE_LINE_BREAK: ctrl.clear = 1'b1;
                default:         ;
            endcase
        end
    end

    // row of cells, each fed by the prefix flag of its left neighbor
    assign chain[0] = 1'b1;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic [BYTE_W-1:0] pattern_byte;

        if (i < REG_BYTES)
        begin : g_byte
            assign pattern_byte =
                bytes_reg[i / BYTES_PER_REG][(i % BYTES_PER_REG) * BYTE_W +: BYTE_W];
        end
        else
        begin : g_zero
            assign pattern_byte = '0;
        end

        kmp_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .pattern_byte (pattern_byte),
            .last_index   (last_index),
            .prev_match   (chain[i]),
            .match        (chain[i+1]),
            .hit          (hit_vec[i])
        );
    end

    assign hit_any = |hit_vec;

    // ready flag and first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_ready_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                table_ready_reg <= 1'b1;
            end
            if (item_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_mode_reg <= item_mode;
        end
    end

    // result of the item in the first stage
    always_comb
    begin
        found_next = 1'b0;
        total_next = total_reg;
        case (s1_mode_reg)
            MODE_START:
            begin
                total_next = '0;
            end
            MODE_TEXT:
            begin
                found_next = hit_any;
                if (hit_any && (total_reg != '1))
                begin
                    total_next = total_reg + TOTAL_W'(1);
                end
            end
            MODE_LINE_BREAK: ;
            default:         ;
        endcase
    end

    // running total and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_found_reg <= found_next;
            out_total_reg <= total_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.match_found = out_found_reg;
    assign results.match_total = out_total_reg;

    // only the final cell can report a hit
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
        else $error("more than one cell reports a completed occurrence");

    // no prefix is tracked before the first start
    assert property (@(posedge clk) disable iff (!rst_n)
        !table_ready_reg |-> (hit_vec == '0))
        else $error("cell hit before the pattern was loaded");

    // a start result reports a cleared total and no match
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (s1_mode_reg == MODE_START))
        |=> (out_total_reg == '0) && !out_found_reg)
        else $error("start result not cleared");

    // between starts the total never falls
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (s1_mode_reg != MODE_START)) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased");

endmodule

`default_nettype wire

// ===== verif/tb_kmp_occurrence_counter.sv =====
// ----------------------------------------------------------------------------
// tb_kmp_occurrence_counter
// Self-checking bench for the pattern occurrence counter. A behavioral
// counter built into the bench follows every accepted item and queues the
// expected match flag and running total. Each result transaction is checked
// against the oldest queued entry. Directed cases come first, then random
// searches over many pattern settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_kmp_occurrence_counter;
    import kmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PATTERN_MAX   = 32;
    localparam int unsigned ITEM_TARGET   = 2000;
    localparam int unsigned QUIET_FROM    = 1700;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned PRINT_CAP     = 40;

    typedef struct packed {
        logic               found;
        logic [TOTAL_W-1:0] total;
    } tally_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    kmp_item_if   items_ch ();
    kmp_result_if results_ch ();

    kmp_occurrence_counter #(
        .MAX_PATTERN(PATTERN_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch.sink),
        .results (results_ch.source),
        .wr_en   (wr_en),
        .wr_index(wr_index),
        .wr_data (wr_data)
    );

    // expected results still to come, oldest first
    tally_t pending_tallies[$];

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;

    // register copies as written
    logic [LEN_W-1:0]      reg_len_q = 6'd1;
    logic [CFG_DATA_W-1:0] reg_words[NUM_BYTE_REGS] = '{default: '0};

    // search state of the behavioral counter
    logic [BYTE_W-1:0]  held_bytes[PATTERN_MAX] = '{default: '0};
    int unsigned        fail_link[PATTERN_MAX] = '{default: 0};
    int unsigned        held_len = 1;
    int unsigned        match_pos = 0;
    logic [TOTAL_W-1:0] occ_total = '0;
    bit                 table_ready = 1'b0;

    always #5 clk = ~clk;

    // latch the pattern registers and build the failure links
    function automatic void latch_pattern();
        int unsigned k;
        held_len = (reg_len_q == 0) ? 1 : (reg_len_q > PATTERN_MAX) ? PATTERN_MAX : reg_len_q;
        for (int unsigned q = 0; q < held_len; q++)
            held_bytes[q] = reg_words[q / 8][(q % 8) * 8 +: 8];
        k = 0;
        fail_link[0] = 0;
        for (int unsigned q = 1; q < held_len; q++)
        begin
            while (k > 0 && held_bytes[k] != held_bytes[q])
                k = fail_link[k - 1];
            if (held_bytes[k] == held_bytes[q])
                k++;
            fail_link[q] = k;
        end
    endfunction

    // advance the search by one item and return the expected result
    function automatic tally_t count_step(mode_t m, logic [BYTE_W-1:0] c);
        tally_t      res;
        int unsigned q;
        res.found = 1'b0;
        case (m)
            MODE_START:
            begin
                latch_pattern();
                match_pos = 0;
                occ_total = '0;
                table_ready = 1'b1;
            end
            MODE_TEXT:
            begin
                if (table_ready)
                begin
                    q = (match_pos >= held_len) ? 0 : match_pos;
                    while (q > 0 && held_bytes[q] != c)
                        q = fail_link[q - 1];
                    if (held_bytes[q] == c)
                        q++;
                    if (q == held_len)
                    begin
                        res.found = 1'b1;
                        if (occ_total != '1)
                            occ_total++;
                        q = fail_link[q - 1];
                    end
                    match_pos = q;
                end
            end
            MODE_LINE_BREAK:
                match_pos = 0;
            default:
                ;
        endcase
        res.total = occ_total;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // one item transaction, at times with a random gap in front of it
    task automatic send_item(mode_t m, logic [BYTE_W-1:0] c);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            items_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        items_ch.valid     <= 1'b1;
        items_ch.mode      <= m;
        items_ch.text_byte <= c;
        do
            @(posedge clk);
        while (!items_ch.ready);
        pending_tallies.push_back(count_step(m, c));
        items_sent++;
        @(negedge clk);
    endtask

    // stop sending and let every expected result come out
    task automatic drain_results();
        items_ch.valid <= 1'b0;
        while (pending_tallies.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
    endtask

    // write all five registers, block must be idle
    task automatic write_config(logic [LEN_W-1:0] len,
                                logic [CFG_DATA_W-1:0] words[NUM_BYTE_REGS]);
        put_reg(REG_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, len});
        put_reg(REG_BYTES_0, words[0]);
        put_reg(REG_BYTES_8, words[1]);
        put_reg(REG_BYTES_16, words[2]);
        put_reg(REG_BYTES_24, words[3]);
        wr_en <= 1'b0;
        reg_len_q = len;
        for (int i = 0; i < NUM_BYTE_REGS; i++)
            reg_words[i] = words[i];
    endtask

    // text before any start never matches, even against the reset pattern
    task automatic test_text_before_start();
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_LINE_BREAK, 8'hA5);
        send_item(MODE_TEXT, 8'h00);
    endtask

    // start with reset registers: single zero byte pattern
    task automatic test_reset_pattern();
        send_item(MODE_START, 8'h00);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'h5A);
    endtask

    // overlapping occurrences, and a line break that cuts a partial match
    task automatic test_overlap_and_line_break();
        drain_results();
        write_config(6'd3, '{64'hFFFF_FFFF_FFFF_00FF, 64'h0,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF});
        send_item(MODE_START, 8'hFF);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_LINE_BREAK, 8'h00);
        send_item(MODE_TEXT, 8'hFF);
    endtask

    // new register values act only at the next start
    task automatic test_pattern_change_mid_search();
        drain_results();
        write_config(6'd1, '{64'h41, 64'h0, 64'h0, 64'h0});
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_START, 8'h7E);
        send_item(MODE_TEXT, 8'h41);
    endtask

    // random searches: small alphabets with embedded copies of the pattern
    task automatic test_random_search();
        int unsigned           phase;
        int unsigned           phase_len;
        int unsigned           n;
        int unsigned           alpha_n;
        int unsigned           eff;
        int unsigned           r;
        logic [BYTE_W-1:0]     alpha[4];
        logic [LEN_W-1:0]      len;
        logic [CFG_DATA_W-1:0] words[NUM_BYTE_REGS];
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            drain_results();
            idle_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            alpha_n = $urandom_range(1, 4);
            for (int k = 0; k < 4; k++)
                alpha[k] = BYTE_W'($urandom_range(0, 255));
            // extreme lengths first, out-of-range ones included
            case (phase)
                0: len = 6'd0;
                1: len = 6'd63;
                2: len = 6'd32;
                3: len = 6'd1;
                4: len = 6'd33;
                5: len = 6'd31;
                default: len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 63))
                                                             : LEN_W'($urandom_range(1, 6));
            endcase
            for (int k = 0; k < NUM_BYTE_REGS; k++)
                words[k] = {$urandom, $urandom};
            eff = (len == 0) ? 1 : (len > PATTERN_MAX) ? PATTERN_MAX : len;
            for (int unsigned k = 0; k < eff; k++)
                words[k / 8][(k % 8) * 8 +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
            write_config(len, words);
            // now and then keep searching with the old pattern
            if (phase == 0 || $urandom_range(0, 9) != 0)
                send_item(MODE_START, BYTE_W'($urandom_range(0, 255)));
            phase_len = (eff > 8) ? $urandom_range(80, 200) : $urandom_range(30, 150);
            n = 0;
            while (n < phase_len)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    for (int unsigned k = 0; k < held_len; k++)
                        send_item(MODE_TEXT, held_bytes[k]);
                    n += held_len;
                end
                else
                begin
                    if (r < 13)
                        send_item(MODE_LINE_BREAK, BYTE_W'($urandom_range(0, 255)));
                    else if (r < 15)
                        send_item(MODE_START, BYTE_W'($urandom_range(0, 255)));
                    else if (r < 22)
                        send_item(MODE_TEXT, BYTE_W'($urandom_range(0, 255)));
                    else
                        send_item(MODE_TEXT, alpha[$urandom_range(0, alpha_n - 1)]);
                    n++;
                end
            end
            phase++;
        end
    endtask

    // result channel back-pressure
    initial
    begin
        int unsigned stall;
        results_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 14);
                results_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_results
        tally_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_tallies.size() == 0)
                report_mismatch($sformatf("result with nothing expected (found %0b total %0d)",
                                          results_ch.match_found, results_ch.match_total));
            else
            begin
                want = pending_tallies.pop_front();
                if (results_ch.match_found !== want.found)
                    report_mismatch($sformatf("match_found %b, expected %b",
                                              results_ch.match_found, want.found));
                if (results_ch.match_total !== want.total)
                    report_mismatch($sformatf("match_total %0d, expected %0d",
                                              results_ch.match_total, want.total));
            end
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_kmp_occurrence_counter: FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n              = 1'b0;
        wr_en              = 1'b0;
        wr_index           = '0;
        wr_data            = '0;
        items_ch.valid     = 1'b0;
        items_ch.mode      = '0;
        items_ch.text_byte = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_text_before_start();
        test_reset_pattern();
        test_overlap_and_line_break();
        test_pattern_change_mid_search();
        test_random_search();
        drain_results();

        if (mismatches == 0)
            $display("tb_kmp_occurrence_counter: PASS");
        else
            $display("tb_kmp_occurrence_counter: FAIL");
        $finish;
    end

endmodule

// ===== kmp_occurrence_counter.f =====
rtl/kmp_pkg.sv
rtl/kmp_if.sv
rtl/kmp_cell.sv
rtl/kmp_occurrence_counter.sv
verif/tb_kmp_occurrence_counter.sv
